/* rtl/lrc_pkg.sv */
// Shared constants, types and command/status structs for the LRC time-tag line parser.
package lrc_pkg;

  localparam int MAX_TAGS = 16;
  localparam int ACC_BITS = 16;
  localparam int CNT_W    = $clog2(MAX_TAGS + 1);
  localparam int IDX_W    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int BASE_W   = ACC_BITS + 6;
  localparam int V_W      = (ACC_BITS + 20 > 33) ? ACC_BITS + 20 : 33;
  localparam int T_W      = V_W - 4;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LBR   = 8'h5B;
  localparam logic [7:0] CHAR_RBR   = 8'h5D;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_TIME = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FLD_MIN  = 2'd0,
    FLD_SEC  = 2'd1,
    FLD_FRAC = 2'd2
  } field_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3,
    ST_END
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic take_byte;
    logic calc1;
    logic calc2;
    logic calc3;
    logic push_time;
    logic push_end;
  } cmd_t;

  typedef struct packed {
    logic is_lf;
    logic eot;
    logic ev_content;
    logic ev_store;
    logic line_valid;
    logic rep_more;
    logic out_free;
  } status_t;

endpackage

/* rtl/lrc_if.sv */
// Valid/ready channel interfaces for text bytes in and parse records out.
interface lrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface lrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_char;
  logic [31:0] time_ms;
  logic        line_valid;
  logic        tags_dropped;
  logic        last;

  modport source (
    output valid, output kind, output out_char, output time_ms,
    output line_valid, output tags_dropped, output last, input ready
  );
  modport sink (
    input valid, input kind, input out_char, input time_ms,
    input line_valid, input tags_dropped, input last, output ready
  );
endinterface

/* rtl/lrc_ctrl.sv */
// Controller state machine sequencing byte parse, tag time calculation and line-end replay.
module lrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lrc_pkg::status_t  status_i,
  output lrc_pkg::cmd_t     cmd_o
);
  import lrc_pkg::*;

  state_e state_q, state_d;
  logic   byte_wait;
  logic   replay;

  assign byte_wait = status_i.ev_content && !status_i.out_free;
  assign replay    = status_i.line_valid && status_i.rep_more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BYTE;
      end
      ST_BYTE: begin
        if (status_i.is_lf) begin
          state_d = ST_END;
        end else if (!byte_wait) begin
          if (status_i.ev_store) state_d = ST_CALC1;
          else if (status_i.eot) state_d = ST_END;
          else state_d = ST_IDLE;
        end
      end
      ST_CALC1: state_d = ST_CALC2;
      ST_CALC2: state_d = ST_CALC3;
      ST_CALC3: state_d = status_i.eot ? ST_END : ST_IDLE;
      ST_END: begin
        if (status_i.out_free && !replay) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = in_valid_i;
      end
      ST_BYTE: begin
        cmd_o.take_byte = !status_i.is_lf && !byte_wait;
      end
      ST_CALC1: cmd_o.calc1 = 1'b1;
      ST_CALC2: cmd_o.calc2 = 1'b1;
      ST_CALC3: cmd_o.calc3 = 1'b1;
      ST_END: begin
        if (status_i.out_free) begin
          cmd_o.push_time = replay;
          cmd_o.push_end  = !replay;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/lrc_dp.sv */
// Datapath: line state, tag accumulators, time arithmetic, tag store and output register.
module lrc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrc_pkg::cmd_t     cmd_i,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_text_i,
  input  logic              out_ready_i,
  output lrc_pkg::status_t  status_o,
  output logic              out_valid_o,
  output logic [1:0]        kind_o,
  output logic [7:0]        out_char_o,
  output logic [31:0]       time_ms_o,
  output logic              line_valid_o,
  output logic              tags_dropped_o,
  output logic              last_o
);
  import lrc_pkg::*;

  function automatic logic [ACC_BITS-1:0] sat_digit(input logic [ACC_BITS-1:0] acc,
                                                    input logic [3:0] d);
    logic [ACC_BITS+3:0] v;
    v = (ACC_BITS+4)'(acc) * (ACC_BITS+4)'(10) + (ACC_BITS+4)'(d);
    if (v > (ACC_BITS+4)'({ACC_BITS{1'b1}})) return {ACC_BITS{1'b1}};
    return v[ACC_BITS-1:0];
  endfunction

  logic [7:0]          byte_q;
  logic                eot_q;
  logic                in_tag_q, in_tag_d;
  logic                skip_q, skip_d;
  logic                seen_q, seen_d;
  logic                ignored_q, ignored_d;
  logic                started_q, started_d;
  logic                ovf_q, ovf_d;
  logic [1:0]          field_q, field_d;
  logic [ACC_BITS-1:0] min_q, min_d;
  logic [ACC_BITS-1:0] sec_q, sec_d;
  logic [ACC_BITS-1:0] frac_q, frac_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    rep_q, rep_d;
  logic [BASE_W-1:0]   base_q;
  logic [T_W-1:0]      t_q;
  logic [31:0]         tag_times_q [MAX_TAGS];

  logic                out_valid_q;
  kind_e               kind_q;
  logic [7:0]          out_char_q;
  logic [31:0]         time_q;
  logic                line_valid_q;
  logic                dropped_q;
  logic                last_q;

  logic                is_digit;
  logic                room;
  logic                cs;
  logic                push_content;
  logic                out_free;
  logic [V_W-1:0]      v_full;
  logic [31:0]         v_sat;

  assign is_digit = byte_q inside {[CHAR_ZERO:CHAR_NINE]};
  assign room     = count_q < CNT_W'(MAX_TAGS);
  assign cs       = frac_q < ACC_BITS'(100);
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.is_lf      = byte_q == CHAR_LF;
  assign status_o.eot        = eot_q;
  assign status_o.ev_content = !ignored_q && !in_tag_q && byte_q != CHAR_LBR && seen_q &&
                               (started_q || byte_q != CHAR_SPACE);
  assign status_o.ev_store   = !ignored_q && in_tag_q && !skip_q && byte_q == CHAR_RBR && room;
  assign status_o.line_valid = count_q != '0 && started_q;
  assign status_o.rep_more   = rep_q < count_q;
  assign status_o.out_free   = out_free;

  assign push_content = cmd_i.take_byte && status_o.ev_content;

  assign v_full = cs ? V_W'(t_q) * V_W'(10) : V_W'(t_q);
  assign v_sat  = (|v_full[V_W-1:32]) ? 32'hFFFF_FFFF : v_full[31:0];

  always_comb begin
    in_tag_d  = in_tag_q;
    skip_d    = skip_q;
    seen_d    = seen_q;
    ignored_d = ignored_q;
    started_d = started_q;
    ovf_d     = ovf_q;
    field_d   = field_q;
    min_d     = min_q;
    sec_d     = sec_q;
    frac_d    = frac_q;
    count_d   = count_q;
    rep_d     = rep_q;
    if (cmd_i.take_byte && !ignored_q) begin
      if (!in_tag_q) begin
        if (byte_q == CHAR_LBR) begin
          in_tag_d = 1'b1;
          skip_d   = 1'b0;
          field_d  = FLD_MIN;
          min_d    = '0;
          sec_d    = '0;
          frac_d   = '0;
        end else if (!seen_q) begin
          ignored_d = 1'b1;
        end else if (status_o.ev_content) begin
          started_d = 1'b1;
        end
      end else if (skip_q) begin
        if (byte_q == CHAR_RBR) in_tag_d = 1'b0;
      end else if (byte_q == CHAR_RBR) begin
        in_tag_d = 1'b0;
        seen_d   = 1'b1;
        if (!room) ovf_d = 1'b1;
      end else if (is_digit) begin
        case (field_q)
          FLD_MIN: min_d  = sat_digit(min_q, byte_q[3:0]);
          FLD_SEC: sec_d  = sat_digit(sec_q, byte_q[3:0]);
          default: frac_d = sat_digit(frac_q, byte_q[3:0]);
        endcase
      end else if (byte_q == CHAR_COLON) begin
        field_d = FLD_SEC;
      end else if (byte_q == CHAR_DOT) begin
        field_d = FLD_FRAC;
      end else if (byte_q != CHAR_SPACE) begin
        skip_d = 1'b1;
      end
    end
    if (cmd_i.calc3) count_d = count_q + CNT_W'(1);
    if (cmd_i.push_time) rep_d = rep_q + CNT_W'(1);
    if (cmd_i.push_end) begin
      in_tag_d  = 1'b0;
      skip_d    = 1'b0;
      seen_d    = 1'b0;
      ignored_d = 1'b0;
      started_d = 1'b0;
      ovf_d     = 1'b0;
      field_d   = FLD_MIN;
      min_d     = '0;
      sec_d     = '0;
      frac_d    = '0;
      count_d   = '0;
      rep_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q  <= 1'b0;
      skip_q    <= 1'b0;
      seen_q    <= 1'b0;
      ignored_q <= 1'b0;
      started_q <= 1'b0;
      ovf_q     <= 1'b0;
      field_q   <= FLD_MIN;
      min_q     <= '0;
      sec_q     <= '0;
      frac_q    <= '0;
      count_q   <= '0;
      rep_q     <= '0;
    end else begin
      in_tag_q  <= in_tag_d;
      skip_q    <= skip_d;
      seen_q    <= seen_d;
      ignored_q <= ignored_d;
      started_q <= started_d;
      ovf_q     <= ovf_d;
      field_q   <= field_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      frac_q    <= frac_d;
      count_q   <= count_d;
      rep_q     <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= char_code_i;
      eot_q  <= end_of_text_i;
    end
    if (cmd_i.calc1) begin
      base_q <= BASE_W'(sec_q) + BASE_W'(min_q) * BASE_W'(60);
    end
    if (cmd_i.calc2) begin
      t_q <= cs ? T_W'(frac_q) + T_W'(base_q) * T_W'(100)
                : T_W'(frac_q) + T_W'(base_q) * T_W'(1000);
    end
    if (cmd_i.calc3) begin
      tag_times_q[count_q[IDX_W-1:0]] <= v_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_content || cmd_i.push_time || cmd_i.push_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_content) begin
      kind_q       <= KIND_CHAR;
      out_char_q   <= byte_q;
      time_q       <= '0;
      line_valid_q <= 1'b0;
      dropped_q    <= 1'b0;
      last_q       <= !eot_q;
    end else if (cmd_i.push_time) begin
      kind_q       <= KIND_TIME;
      out_char_q   <= '0;
      time_q       <= tag_times_q[rep_q[IDX_W-1:0]];
      line_valid_q <= 1'b0;
      dropped_q    <= 1'b0;
      last_q       <= 1'b0;
    end else if (cmd_i.push_end) begin
      kind_q       <= KIND_END;
      out_char_q   <= '0;
      time_q       <= '0;
      line_valid_q <= status_o.line_valid;
      dropped_q    <= ovf_q;
      last_q       <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign out_char_o     = out_char_q;
  assign time_ms_o      = time_q;
  assign line_valid_o   = line_valid_q;
  assign tags_dropped_o = dropped_q;
  assign last_o         = last_q;

endmodule

/* rtl/lrc_timestamp_line_parser.sv */
// Top level of the LRC time-tag line parser: controller plus datapath.
// Usage:
//   char_i takes one text byte per item with an end_of_text flag; byte 10 or
//   end_of_text closes the line. res_o gives records: content bytes (kind 0)
//   as they arrive, then at line end the stored tag times (kind 1) when the
//   line had tags and content, then one line-end record (kind 2). last marks
//   the final record caused by an input item.
// Sequencing:
//   An ordinary byte is accepted in ST_IDLE, then parsed in ST_BYTE, which
//   waits while the output register is full; its record is on res_o in the
//   cycle after the parse. A closing ']' adds the calc states for the tag
//   time arithmetic (base, scale, saturate, store). At line end the single
//   output register carries a valid line's times, then the line-end record.
// Reset:
//   rst_ni clears the line state and the output valid flag, not the record
//   fields or tag store; the tag store is read only below the tag count.
// Stalls:
//   When res_o.ready is low the output register holds its record and the
//   controller waits before pushing the next one; char_i.ready stays low
//   until the current item is fully handled.
module lrc_timestamp_line_parser (
  input logic         clk_i,
  input logic         rst_ni,
  lrc_in_if.sink      char_i,
  lrc_out_if.source   res_o
);
  import lrc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lrc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .char_code_i    (char_i.char_code),
    .end_of_text_i  (char_i.end_of_text),
    .out_ready_i    (res_o.ready),
    .status_o       (status),
    .out_valid_o    (res_o.valid),
    .kind_o         (res_o.kind),
    .out_char_o     (res_o.out_char),
    .time_ms_o      (res_o.time_ms),
    .line_valid_o   (res_o.line_valid),
    .tags_dropped_o (res_o.tags_dropped),
    .last_o         (res_o.last)
  );

  assign char_i.ready = cmd.in_ready;

endmodule

/* rtl/lrc_checker.sv */
// Port-level assertions for the LRC time-tag line parser and their bind.
module lrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [7:0]  out_char_i,
  input logic [31:0] time_ms_i,
  input logic        line_valid_i,
  input logic        tags_dropped_i,
  input logic        last_i
);
  import lrc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(out_char_i) && $stable(time_ms_i) && $stable(line_valid_i) &&
    $stable(tags_dropped_i) && $stable(last_i))
    else $error("output record changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while previous item in work");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_END |-> last_i)
    else $error("line-end record without last");

  a_time_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_TIME |-> !last_i && !line_valid_i && out_char_i == 8'd0)
    else $error("time record with last or stray fields");

endmodule

bind lrc_timestamp_line_parser lrc_checker u_lrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (char_i.valid),
  .in_ready_i     (char_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .out_char_i     (res_o.out_char),
  .time_ms_i      (res_o.time_ms),
  .line_valid_i   (res_o.line_valid),
  .tags_dropped_i (res_o.tags_dropped),
  .last_i         (res_o.last)
);

/* verif/testbench.sv */
// Self-checking testbench for the LRC time-tag line parser: random text lines, checked records.
`timescale 1ns / 1ps

module testbench;
  import lrc_pkg::*;

  localparam longint unsigned ACC_LIMIT = (64'd1 << ACC_BITS) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int LINE_BYTES_PER_PHASE = 105;

  typedef struct packed {
    logic [7:0] code;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_char;
    logic [31:0] time_ms;
    logic        line_valid;
    logic        tags_dropped;
    logic        last;
  } parse_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_char = 8'd0;
  logic       drv_eot = 1'b0;
  logic       drv_ready = 1'b0;
  logic       in_fire = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;
  int mismatches = 0;

  text_item_t text_bytes[$];
  parse_rec_t pending_records[$];
  logic [7:0] line_buf[$];

  // line state of the parser as predicted
  logic p_in_tag, p_skip, p_seen, p_ignored, p_content, p_over;
  field_e p_field;
  logic [ACC_BITS-1:0] p_min, p_sec, p_frac;
  logic [31:0] p_times[MAX_TAGS];
  int p_count;

  lrc_in_if  char_if ();
  lrc_out_if res_if ();

  assign char_if.valid       = drv_valid;
  assign char_if.char_code   = drv_char;
  assign char_if.end_of_text = drv_eot;
  assign res_if.ready        = drv_ready;

  lrc_timestamp_line_parser uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_if),
    .res_o  (res_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_rec(kind_e k, logic [7:0] c, logic [31:0] t, logic v,
                                   logic d);
    parse_rec_t r;
    r = '{kind: k, out_char: c, time_ms: t, line_valid: v, tags_dropped: d, last: 1'b0};
    pending_records.insert(pending_records.size(), r);
  endfunction

  function automatic void append_byte(logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  function automatic void append_item(logic [7:0] c, logic e);
    text_item_t it;
    it.code = c;
    it.eot = e;
    text_bytes.insert(text_bytes.size(), it);
  endfunction

  function automatic logic [ACC_BITS-1:0] acc_digit(logic [ACC_BITS-1:0] acc,
                                                    logic [7:0] d);
    longint unsigned v;
    v = 64'(acc) * 10 + 64'(d);
    return (v > ACC_LIMIT) ? ACC_BITS'(ACC_LIMIT) : ACC_BITS'(v);
  endfunction

  task automatic clear_line();
    p_in_tag = 1'b0;
    p_skip = 1'b0;
    p_seen = 1'b0;
    p_ignored = 1'b0;
    p_content = 1'b0;
    p_over = 1'b0;
    p_field = FLD_MIN;
    p_min = '0;
    p_sec = '0;
    p_frac = '0;
    p_count = 0;
  endtask

  task automatic close_line();
    logic valid;
    valid = (p_count > 0) && p_content;
    if (valid) begin
      for (int i = 0; i < p_count; i++) push_rec(KIND_TIME, 8'd0, p_times[i], 1'b0, 1'b0);
    end
    push_rec(KIND_END, 8'd0, 32'd0, valid, p_over);
    clear_line();
  endtask

  task automatic parse_byte(logic [7:0] ch, logic eot);
    int n0;
    longint unsigned base, ms;
    n0 = pending_records.size();
    if (ch == CHAR_LF) begin
      close_line();
    end else begin
      if (!p_ignored) begin
        if (!p_in_tag) begin
          if (ch == CHAR_LBR) begin
            p_in_tag = 1'b1;
            p_skip = 1'b0;
            p_field = FLD_MIN;
            p_min = '0;
            p_sec = '0;
            p_frac = '0;
          end else if (!p_seen) begin
            p_ignored = 1'b1;
          end else if (p_content || ch != CHAR_SPACE) begin
            p_content = 1'b1;
            push_rec(KIND_CHAR, ch, 32'd0, 1'b0, 1'b0);
          end
        end else if (p_skip) begin
          if (ch == CHAR_RBR) p_in_tag = 1'b0;
        end else if (ch == CHAR_RBR) begin
          p_in_tag = 1'b0;
          p_seen = 1'b1;
          if (p_count < MAX_TAGS) begin
            base = 64'(p_sec) + 64'(p_min) * 60;
            if (p_frac < 100) ms = (64'(p_frac) + base * 100) * 10;
            else ms = 64'(p_frac) + base * 1000;
            p_times[p_count] = (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
            p_count++;
          end else begin
            p_over = 1'b1;
          end
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          case (p_field)
            FLD_MIN: p_min = acc_digit(p_min, ch - CHAR_ZERO);
            FLD_SEC: p_sec = acc_digit(p_sec, ch - CHAR_ZERO);
            default: p_frac = acc_digit(p_frac, ch - CHAR_ZERO);
          endcase
        end else if (ch == CHAR_COLON) begin
          p_field = FLD_SEC;
        end else if (ch == CHAR_DOT) begin
          p_field = FLD_FRAC;
        end else if (ch != CHAR_SPACE) begin
          p_skip = 1'b1;
        end
      end
      if (eot) close_line();
    end
    if (pending_records.size() > n0) begin
      pending_records[pending_records.size() - 1].last = 1'b1;
    end
  endtask

  // driver: offer the next item, hold it until accepted
  always @(negedge clk) begin
    text_item_t it;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !in_fire) begin
      drv_valid <= 1'b1;
    end else if (text_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      it = text_bytes.pop_front();
      drv_valid <= 1'b1;
      drv_char <= it.code;
      drv_eot <= it.eot;
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_tog != hold_ack) begin
      hold_ack <= hold_tog;
      hold_left <= HOLD_CYCLES;
      drv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      drv_ready <= 1'b0;
    end else begin
      drv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    in_fire <= drv_valid && char_if.ready;
    if (rst_n && drv_valid && char_if.ready) parse_byte(drv_char, drv_eot);
  end

  always @(posedge clk) begin
    parse_rec_t r;
    if (rst_n && res_if.valid && drv_ready) begin
      if (pending_records.size() == 0) begin
        $error("record with nothing expected: kind %0d char %0d time %0d",
               res_if.kind, res_if.out_char, res_if.time_ms);
        mismatches++;
      end else begin
        r = pending_records.pop_front();
        if (res_if.kind !== r.kind) begin
          $error("kind: expected %0d, actual %0d", r.kind, res_if.kind);
          mismatches++;
        end
        if (res_if.out_char !== r.out_char) begin
          $error("out_char: expected %0d, actual %0d", r.out_char, res_if.out_char);
          mismatches++;
        end
        if (res_if.time_ms !== r.time_ms) begin
          $error("time_ms: expected %0d, actual %0d", r.time_ms, res_if.time_ms);
          mismatches++;
        end
        if (res_if.line_valid !== r.line_valid) begin
          $error("line_valid: expected %0d, actual %0d", r.line_valid, res_if.line_valid);
          mismatches++;
        end
        if (res_if.tags_dropped !== r.tags_dropped) begin
          $error("tags_dropped: expected %0d, actual %0d", r.tags_dropped,
                 res_if.tags_dropped);
          mismatches++;
        end
        if (res_if.last !== r.last) begin
          $error("last: expected %0d, actual %0d", r.last, res_if.last);
          mismatches++;
        end
      end
    end
  end

  task automatic push_text(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      append_item(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  task automatic add_digits();
    int r, n;
    r = $urandom_range(9);
    n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6);
    repeat (n) append_byte(CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_tag(bit brief);
    logic [7:0] c;
    append_byte(CHAR_LBR);
    if (brief) begin
      if ($urandom_range(1) != 0) append_byte(CHAR_ZERO + 8'($urandom_range(9)));
    end else begin
      if ($urandom_range(9) == 0) append_byte(CHAR_SPACE);
      add_digits();
      if ($urandom_range(7) != 0) begin
        append_byte(CHAR_COLON);
        add_digits();
      end
      if ($urandom_range(7) != 0) begin
        append_byte(CHAR_DOT);
        add_digits();
      end
      if ($urandom_range(11) == 0) begin
        do c = 8'($urandom_range(255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON || c == CHAR_DOT ||
               c == CHAR_SPACE || c == CHAR_RBR || c == CHAR_LF);
        append_byte(c);
        if ($urandom_range(1) != 0) add_digits();
      end
    end
    append_byte(CHAR_RBR);
  endtask

  task automatic add_line(output int n);
    int mode, r;
    logic [7:0] c;
    logic eot_last;
    line_buf.delete();
    mode = $urandom_range(99);
    if (mode < 85) begin
      repeat ((mode < 4) ? $urandom_range(17, 18) : $urandom_range(1, 3)) add_tag(mode < 4);
      repeat ($urandom_range(0, 2)) append_byte(CHAR_SPACE);
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom_range(255));
        while (c == CHAR_LF);
        append_byte(c);
      end
    end else begin
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(255)));
    end
    // end the line by end_of_text alone, by LF with end_of_text, or by LF
    r = $urandom_range(3);
    eot_last = (r < 2);
    if (r != 0) append_byte(CHAR_LF);
    n = line_buf.size();
    foreach (line_buf[i]) begin
      append_item(line_buf[i], eot_last && (i == line_buf.size() - 1));
    end
  endtask

  task automatic wait_drained();
    while (text_bytes.size() > 0 || drv_valid || pending_records.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int count, n;
    idle_tab = '{0, 46, 0, 31};
    stall_tab = '{0, 0, 46, 31};
    clear_line();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) begin
        push_text("x\n", 1'b0);
        push_text("[9:59.99]  z", 1'b1);
        push_text("[a]\n", 1'b0);
        push_text("[]", 1'b0);
        append_item(8'hFF, 1'b1);
        push_text("\n", 1'b1);
        push_text("[1\n", 1'b0);
      end
      count = 0;
      while (count < LINE_BYTES_PER_PHASE) begin
        add_line(n);
        count += n;
      end
      if (ph == 2) hold_tog = ~hold_tog;
      wait_drained();
    end
    repeat (30) @(negedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
